/* rtl/tcw_pkg.sv */
// tcw_pkg: shared constants, codes and types of the text console writer.
// Used by every module under rtl/ except tcw_ram; depends on nothing.

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);

	localparam int CURSOR_W  = 11;
	localparam int CELL_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int RADDR_W   = 11;
	localparam int KIND_W    = 2;
	localparam int COLOR_W   = 4;
	localparam int ATTR_W    = 2 * COLOR_W;
	localparam int CFG_IDX_W = 1;

	localparam int S_TDATA_W = 24;
	localparam int S_PAD_W   = S_TDATA_W - CHAR_W - RADDR_W;
	localparam int M_TDATA_W = 32;
	localparam int M_PAD_W   = M_TDATA_W - CURSOR_W - CELL_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0]  NUL_CODE     = 8'h00;
	localparam logic [ATTR_W-1:0]  BLANK_ATTR   = 8'h07;
	localparam logic [CELL_W-1:0]  BLANK_CELL   = {BLANK_ATTR, SPACE_CODE};
	localparam logic [COLOR_W-1:0] FG_RESET     = 4'h7;
	localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOREGROUND = 1'b0,
		REG_BACKGROUND = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                clear;
		logic                scroll;
		logic                write;
		logic                read;
		logic                read_ok;
		logic [ADDR_W-1:0]   addr;
		logic [CELL_W-1:0]   cell_word;
		logic [CURSOR_W-1:0] pos;
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

endpackage

/* rtl/text_console_writer.sv */
// text_console_writer: top level of the character-cell text console.
// Instantiates tcw_front, tcw_queue, tcw_back and tcw_ram; uses tcw_pkg.
//
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid/tready      request: kind, char_code, read_address
// m_*       out        tvalid/tready      result: cursor_position, cell_data
// cfg_*     in         cfg_we             foreground_color, background_color
//
// A scroll and a clear each rewrite the whole cell RAM through its single write port.
// After reset a clearing pass fills all CELLS cells (2000 at 80 x 25)
// with blanks; s_tready stays low meanwhile.
// A 4-entry command queue lets requests enter while the back end or m_tready stalls.

module text_console_writer import tcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // char_code[7:0], read_address[18:8]
	input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // cursor_position[10:0], cell_data[26:11]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data
);

	logic [COLOR_W-1:0]  fg_q;
	logic [COLOR_W-1:0]  bg_q;
	logic [ATTR_W-1:0]   attr;

	logic                q_push;
	cmd_t                q_cmd;
	logic                q_full;
	logic                q_valid;
	cmd_t                q_head;
	logic                q_pop;
	logic                room;
	ram_req_t            ram;
	logic [CELL_W-1:0]   rdata;
	back_status_t        status;
	logic [CURSOR_W-1:0] out_pos;
	logic [CELL_W-1:0]   out_data;

	assign attr    = {bg_q, fg_q};
	assign room    = !q_full && !status.init_busy;
	assign m_tdata = {{M_PAD_W{1'b0}}, out_data, out_pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOREGROUND: fg_q <= cfg_data;
				REG_BACKGROUND: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_char  (s_tdata[CHAR_W-1:0]),
		.in_raddr (s_tdata[CHAR_W +: RADDR_W]),
		.attr     (attr),
		.room     (room),
		.push     (q_push),
		.cmd      (q_cmd)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.attr       (attr),
		.ram        (ram),
		.rdata      (rdata),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pos    (out_pos),
		.out_data   (out_data)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		status.init_busy |-> !s_tready)
		else $error("request accepted during clearing pass");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command queue underflow");

endmodule

/* rtl/tcw_ram.sv */
// tcw_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package needed.

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/tcw_front.sv */
// tcw_front: accepts requests, tracks the cursor and turns each request
// into a store command for the back end. Depends on tcw_pkg.

module tcw_front import tcw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   in_kind,
	input  logic [CHAR_W-1:0]   in_char,
	input  logic [RADDR_W-1:0]  in_raddr,
	input  logic [ATTR_W-1:0]   attr,
	input  logic                room,
	output logic                push,
	output cmd_t                cmd
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] base_q;

	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [ADDR_W-1:0] base_n;
	logic              bottom;
	logic              do_nl;
	logic              do_write;

	assign in_ready = room;
	assign push     = in_valid && room;
	assign bottom   = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		do_nl    = 1'b0;
		do_write = 1'b0;
		col_n    = col_q;
		row_n    = row_q;
		base_n   = base_q;
		cmd      = '0;
		unique case (kind_t'(in_kind))
			KIND_WRITE: begin
				if (in_char == NEWLINE_CODE) begin
					do_nl = 1'b1;
				end else begin
					do_nl    = (col_q == COL_W'(COLUMNS));
					do_write = 1'b1;
				end
			end
			KIND_FINISH: begin
				do_nl = (col_q != '0);
			end
			KIND_READ: begin
				cmd.read    = 1'b1;
				cmd.read_ok = (32'(in_raddr) < 32'(CELLS));
				cmd.addr    = ADDR_W'(in_raddr);
			end
			KIND_CLEAR: begin
				cmd.clear = 1'b1;
				col_n     = '0;
				row_n     = '0;
				base_n    = '0;
			end
			default: ;
		endcase
		if (do_nl) begin
			col_n      = '0;
			cmd.scroll = bottom;
			if (!bottom) begin
				row_n  = row_q + ROW_W'(1);
				base_n = base_q + ADDR_W'(COLUMNS);
			end
		end
		if (do_write) begin
			cmd.write     = 1'b1;
			cmd.addr      = base_n + ADDR_W'(col_n);
			cmd.cell_word = {attr, in_char};
			col_n         = col_n + COL_W'(1);
		end
		cmd.pos = CURSOR_W'(POS_W'(base_n) + POS_W'(col_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (push) begin
			col_q  <= col_n;
			row_q  <= row_n;
			base_q <= base_n;
		end
	end

endmodule

/* rtl/tcw_queue.sv */
// tcw_queue: short command FIFO between front and back end.
// Depends on tcw_pkg.

module tcw_queue import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

/* rtl/tcw_back.sv */
// tcw_back: carries out store commands (write, read, scroll copy, fill)
// on the cell RAM and holds the result register. Depends on tcw_pkg.

module tcw_back import tcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cmd_t                  head,
	output logic                  pop,
	input  logic [ATTR_W-1:0]     attr,
	output ram_req_t              ram,
	input  logic [CELL_W-1:0]     rdata,
	output back_status_t          status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CURSOR_W-1:0]   out_pos,
	output logic [CELL_W-1:0]     out_data
);

	typedef enum logic [6:0] {
		ST_FILL   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_COPY   = 7'b0000100,
		ST_BOTTOM = 7'b0001000,
		ST_FINAL  = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

	state_t              state_q;
	cmd_t                cmd_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic                init_q;
	logic                cp_wr_s1;
	logic [ADDR_W-1:0]   cp_addr_s1;
	logic                out_valid_q;
	logic [CURSOR_W-1:0] out_pos_q;
	logic [CELL_W-1:0]   out_data_q;

	logic                out_free;
	logic                load;
	logic [CURSOR_W-1:0] load_pos;
	logic [CELL_W-1:0]   load_data;

	assign out_free         = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign out_pos          = out_pos_q;
	assign out_data         = out_data_q;
	assign status.init_busy = init_q;

	always_comb begin
		ram       = '0;
		pop       = 1'b0;
		load      = 1'b0;
		load_pos  = cmd_q.pos;
		load_data = '0;
		unique case (state_q)
			ST_FILL: begin
				ram.we    = 1'b1;
				ram.waddr = cnt_q;
				ram.wdata = BLANK_CELL;
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					if (!head.clear && !head.scroll) begin
						if (head.read) begin
							ram.re    = 1'b1;
							ram.raddr = head.addr;
						end else begin
							ram.we    = head.write;
							ram.waddr = head.addr;
							ram.wdata = head.cell_word;
							load      = out_free;
							load_pos  = head.pos;
						end
					end
				end
			end
			ST_COPY: begin
				ram.we    = cp_wr_s1;
				ram.waddr = cp_addr_s1;
				ram.wdata = rdata;
				if (cnt_q != LAST_COPY) begin
					ram.re    = 1'b1;
					ram.raddr = cnt_q + ADDR_W'(COLUMNS);
				end
			end
			ST_BOTTOM: begin
				ram.we    = 1'b1;
				ram.waddr = cnt_q;
				ram.wdata = {attr, NUL_CODE};
			end
			ST_FINAL: begin
				ram.we    = cmd_q.write;
				ram.waddr = cmd_q.addr;
				ram.wdata = cmd_q.cell_word;
			end
			ST_READ: begin
				load      = out_free;
				load_data = cmd_q.read_ok ? rdata : '0;
			end
			ST_DONE: begin
				load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			init_q      <= 1'b1;
			cp_wr_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cp_wr_s1 <= 1'b0;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						cnt_q <= '0;
						if (head.clear) begin
							state_q <= ST_FILL;
						end else if (head.scroll) begin
							state_q <= ST_COPY;
						end else if (head.read) begin
							state_q <= ST_READ;
						end else if (!out_free) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_COPY: begin
					if (cnt_q == LAST_COPY) begin
						state_q <= ST_BOTTOM;
					end else begin
						cp_wr_s1 <= 1'b1;
						cnt_q    <= cnt_q + ADDR_W'(1);
					end
				end
				ST_BOTTOM: begin
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_FINAL;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_READ, ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head_valid) begin
			cmd_q <= head;
		end
		if (state_q == ST_COPY) begin
			cp_addr_s1 <= cnt_q;
		end
		if (load) begin
			out_pos_q  <= load_pos;
			out_data_q <= load_data;
		end
	end

endmodule
